// File: rtl/advert_tracker_classifier_assert.svh
// ----------------------------------------------------------------------------
// advert_tracker_classifier_assert.svh
// Assertion macros shared by the tracker classifier RTL.
// ----------------------------------------------------------------------------
`ifndef ADVERT_TRACKER_CLASSIFIER_ASSERT_SVH
`define ADVERT_TRACKER_CLASSIFIER_ASSERT_SVH

// same-cycle implication, off during reset
`define ATC_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define ATC_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/atc_pkg.sv
// ----------------------------------------------------------------------------
// atc_pkg
// Types and signature constants of the advertising tracker classifier.
// ----------------------------------------------------------------------------
package atc_pkg;

   // AD structure types of interest
   localparam logic [7:0] AD_TYPE_MANUFACTURER = 8'hFF;
   localparam logic [7:0] AD_TYPE_SERVICE_DATA = 8'h16;

   // tracker signatures
   localparam logic [15:0] COMPANY_ID_A    = 16'h004C;
   localparam logic [7:0]  COMPANY_A_FIRST = 8'h12;
   localparam logic [15:0] COMPANY_ID_B    = 16'h0075;
   localparam logic [15:0] SERVICE_UUID_C0 = 16'hFEED;
   localparam logic [15:0] SERVICE_UUID_C1 = 16'hFEEC;
   localparam logic [15:0] SERVICE_UUID_B0 = 16'hFD5A;
   localparam logic [15:0] SERVICE_UUID_B1 = 16'hFD59;

   // leading data bytes kept per structure kind
   localparam logic [1:0] MAKER_HEAD_BYTES   = 2'd3;
   localparam logic [1:0] SERVICE_HEAD_BYTES = 2'd2;

   // tracker classes
   localparam logic [1:0] CLASS_MAKER_A   = 2'd0;
   localparam logic [1:0] CLASS_FAMILY_B  = 2'd1;
   localparam logic [1:0] CLASS_SERVICE_C = 2'd2;

   // structure currently being walked
   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_MAKER   = 2'd1,
      KIND_SERVICE = 2'd2
   } kind_type;

   // classification of one payload
   typedef struct packed {
      logic       is_tracker;
      logic [1:0] tracker_class;
   } verdict_type;

endpackage

// File: rtl/atc_parser.sv
// ----------------------------------------------------------------------------
// atc_parser
// Walks the AD structures one byte per accepted word, keeps the heads of the
// first manufacturer and service-data structures, and classifies the payload
// on its last byte. Parse state returns to reset after the last byte.
// ----------------------------------------------------------------------------
`include "advert_tracker_classifier_assert.svh"

module atc_parser #(
   parameter int MAX_PAYLOAD_BYTES = 62
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_valid,
   input  logic [7:0]          adv_byte,
   input  logic                last_byte,
   output atc_pkg::verdict_type verdict
);
   import atc_pkg::*;

   localparam int PosWidth = $clog2(MAX_PAYLOAD_BYTES + 1);
   localparam logic [PosWidth-1:0] PosMax = PosWidth'(MAX_PAYLOAD_BYTES);

   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [7:0]          left_ff, left_in;
   logic                exp_type_ff, exp_type_in;
   logic                halted_ff, halted_in;
   kind_type            kind_ff, kind_in;
   logic                mk_found_ff, mk_found_in;
   logic [7:0]          mk_len_ff, mk_len_in;
   logic [23:0]         mk_head_ff, mk_head_in;
   logic [1:0]          mk_cnt_ff, mk_cnt_in;
   logic                sv_found_ff, sv_found_in;
   logic [7:0]          sv_len_ff, sv_len_in;
   logic [15:0]         sv_head_ff, sv_head_in;
   logic [1:0]          sv_cnt_ff, sv_cnt_in;

   // parse one byte into next-state values
   always_comb begin
      pos_in      = pos_ff;
      left_in     = left_ff;
      exp_type_in = exp_type_ff;
      halted_in   = halted_ff;
      kind_in     = kind_ff;
      mk_found_in = mk_found_ff;
      mk_len_in   = mk_len_ff;
      mk_head_in  = mk_head_ff;
      mk_cnt_in   = mk_cnt_ff;
      sv_found_in = sv_found_ff;
      sv_len_in   = sv_len_ff;
      sv_head_in  = sv_head_ff;
      sv_cnt_in   = sv_cnt_ff;
      if (!halted_ff && (pos_ff < PosMax)) begin
         pos_in = pos_ff + 1'b1;
         if (left_ff == 8'd0) begin
            // length byte
            if (adv_byte == 8'd0) begin
               halted_in = 1'b1;
            end else begin
               left_in     = adv_byte;
               exp_type_in = 1'b1;
            end
            kind_in = KIND_NONE;
         end else begin
            left_in = left_ff - 8'd1;
            if (exp_type_ff) begin
               // type byte: claim the first structure of each kind
               exp_type_in = 1'b0;
               kind_in     = KIND_NONE;
               if (adv_byte == AD_TYPE_MANUFACTURER && !mk_found_ff) begin
                  mk_found_in = 1'b1;
                  mk_len_in   = left_in;
                  kind_in     = KIND_MAKER;
               end else if (adv_byte == AD_TYPE_SERVICE_DATA && !sv_found_ff) begin
                  sv_found_in = 1'b1;
                  sv_len_in   = left_in;
                  kind_in     = KIND_SERVICE;
               end
            end else if (kind_ff == KIND_MAKER) begin
               if (mk_cnt_ff < MAKER_HEAD_BYTES) begin
                  mk_head_in[8*mk_cnt_ff +: 8] = adv_byte;
                  mk_cnt_in = mk_cnt_ff + 2'd1;
               end
            end else if (kind_ff == KIND_SERVICE) begin
               if (sv_cnt_ff < SERVICE_HEAD_BYTES) begin
                  sv_head_in[8*sv_cnt_ff[0] +: 8] = adv_byte;
                  sv_cnt_in = sv_cnt_ff + 2'd1;
               end
            end
            // end of structure drops the capture kind
            if (left_in == 8'd0) begin
               kind_in = KIND_NONE;
            end
         end
      end
   end

   // classify from the updated state, manufacturer match first
   always_comb begin
      verdict = '{is_tracker: 1'b0, tracker_class: CLASS_MAKER_A};
      priority if (mk_found_in && mk_len_in >= 8'd3 && mk_cnt_in >= MAKER_HEAD_BYTES
                   && mk_head_in[15:0] == COMPANY_ID_A
                   && mk_head_in[23:16] == COMPANY_A_FIRST) begin
         verdict = '{is_tracker: 1'b1, tracker_class: CLASS_MAKER_A};
      end else if (mk_found_in && mk_len_in >= 8'd3 && mk_cnt_in >= MAKER_HEAD_BYTES
                   && mk_head_in[15:0] == COMPANY_ID_B) begin
         verdict = '{is_tracker: 1'b1, tracker_class: CLASS_FAMILY_B};
      end else if (sv_found_in && sv_len_in >= 8'd2 && sv_cnt_in >= SERVICE_HEAD_BYTES
                   && (sv_head_in == SERVICE_UUID_C0 || sv_head_in == SERVICE_UUID_C1)) begin
         verdict = '{is_tracker: 1'b1, tracker_class: CLASS_SERVICE_C};
      end else if (sv_found_in && sv_len_in >= 8'd2 && sv_cnt_in >= SERVICE_HEAD_BYTES
                   && (sv_head_in == SERVICE_UUID_B0 || sv_head_in == SERVICE_UUID_B1)) begin
         verdict = '{is_tracker: 1'b1, tracker_class: CLASS_FAMILY_B};
      end else begin
         verdict = '{is_tracker: 1'b0, tracker_class: CLASS_MAKER_A};
      end
   end

   // hold parse state; restart after the last byte
   always_ff @(posedge clock) begin
      if (reset || (byte_valid && last_byte)) begin
         pos_ff      <= '0;
         left_ff     <= 8'd0;
         exp_type_ff <= 1'b0;
         halted_ff   <= 1'b0;
         kind_ff     <= KIND_NONE;
         mk_found_ff <= 1'b0;
         mk_len_ff   <= 8'd0;
         mk_cnt_ff   <= 2'd0;
         sv_found_ff <= 1'b0;
         sv_len_ff   <= 8'd0;
         sv_cnt_ff   <= 2'd0;
      end else if (byte_valid) begin
         pos_ff      <= pos_in;
         left_ff     <= left_in;
         exp_type_ff <= exp_type_in;
         halted_ff   <= halted_in;
         kind_ff     <= kind_in;
         mk_found_ff <= mk_found_in;
         mk_len_ff   <= mk_len_in;
         mk_cnt_ff   <= mk_cnt_in;
         sv_found_ff <= sv_found_in;
         sv_len_ff   <= sv_len_in;
         sv_cnt_ff   <= sv_cnt_in;
      end
   end

   // head bytes are gated by their capture counts
   always_ff @(posedge clock) begin
      if (byte_valid) begin
         mk_head_ff <= mk_head_in;
         sv_head_ff <= sv_head_in;
      end
   end

   `ATC_ASSERT_IMP(a_type_needs_body, clock, reset, exp_type_ff, left_ff != 8'd0,
      "type byte expected with no structure bytes left")
   `ATC_ASSERT_IMP(a_kind_needs_body, clock, reset, kind_ff != KIND_NONE, left_ff != 8'd0,
      "capture kind active outside a structure")
   `ATC_ASSERT_IMP(a_halt_clears_kind, clock, reset, halted_ff,
      kind_ff == KIND_NONE && !exp_type_ff, "parse halted with a structure open")
   `ATC_ASSERT_IMP(a_pos_bound, clock, reset, 1'b1, pos_ff <= PosMax,
      "byte position past the payload bound")

endmodule

// File: rtl/advert_tracker_classifier.sv
// ----------------------------------------------------------------------------
// advert_tracker_classifier
// Classifies an advertising payload as a known tracker from its first
// manufacturer-specific and service-data AD structures.
//
//   channel | dir | tdata                               | tlast
//   req     | in  | [7:0] adv_byte                      | last_byte
//   rsp     | out | [0] is_tracker, [2:1] tracker_class | -
//
// One byte is accepted per cycle while req_tready is high; a result word leaves
// in the cycle after the byte marked last and sits in the output register until taken.
// req_tready drops only while a result waits and rsp_tready is low.
// Synchronous active-high reset clears parse state and the output valid.
// ----------------------------------------------------------------------------
`include "advert_tracker_classifier_assert.svh"

module advert_tracker_classifier #(
   parameter int MAX_PAYLOAD_BYTES = 62
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] adv_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] is_tracker, [2:1] tracker_class, zero fill
);
   import atc_pkg::*;

   logic        req_fire;
   verdict_type verdict;
   logic        rsp_valid_ff;
   verdict_type rsp_word_ff;

   // take a byte whenever the output register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   atc_parser #(
      .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_valid(req_fire),
      .adv_byte  (req_tdata),
      .last_byte (req_tlast),
      .verdict   (verdict)
   );

   // output register: load on the last byte, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire && req_tlast) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_tlast) begin
         rsp_word_ff <= verdict;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_word_ff.tracker_class, rsp_word_ff.is_tracker};

   `ATC_ASSERT_NXT(a_last_gives_result, clock, reset, req_fire && req_tlast, rsp_valid_ff,
      "no result after the last byte")
   `ATC_ASSERT_IMP(a_result_from_last, clock, reset, $rose(rsp_valid_ff),
      $past(req_fire && req_tlast), "result raised without a last byte")
   `ATC_ASSERT_IMP(a_no_match_class, clock, reset, rsp_valid_ff && !rsp_word_ff.is_tracker,
      rsp_word_ff.tracker_class == CLASS_MAKER_A, "class set on a payload with no match")
   `ATC_ASSERT_IMP(a_class_range, clock, reset, rsp_valid_ff,
      rsp_word_ff.tracker_class != 2'd3, "tracker class out of range")

endmodule
